// File: rtl/core/rcwt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcwt_pkg
// Shared types and constants of the textured wall column block: field widths,
// command and register codes, sequencer states and divider status.
// ----------------------------------------------------------------------------
package rcwt_pkg;

    // payload field widths
    localparam int CMD_W  = 1;
    localparam int COL_W  = 12;
    localparam int DIST_W = 24;
    localparam int HIT_W  = 24;
    localparam int FACE_W = 2;
    localparam int PROW_W = 12;
    localparam int TEX_W  = 6;

    // configuration register widths
    localparam int SH_W       = 13;
    localparam int PD_W       = 20;
    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 1;

    // fractional bits of the Q8.16 hit coordinates
    localparam int FRAC_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_LOAD = 1'b0;
    localparam logic [CMD_W-1:0] CMD_TICK = 1'b1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PROJ_DIST     = 1'b1;

    // register reset values
    localparam logic [SH_W-1:0] SH_RESET = 13'd1024;
    localparam logic [PD_W-1:0] PD_RESET = 20'd131072;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_SPAN = 4'b1000
    } t_state;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

`default_nettype wire

// File: rtl/core/rcwt_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcwt_in_if
// Command channel: one column load or one pixel tick per item.
// ----------------------------------------------------------------------------
interface rcwt_in_if;
    import rcwt_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [COL_W-1:0]  column_x;
    logic [DIST_W-1:0] distance;
    logic [HIT_W-1:0]  hit_x;
    logic [HIT_W-1:0]  hit_y;
    logic              hit_side;
    logic [FACE_W-1:0] wall_face;

    modport source (
        output valid, command, column_x, distance, hit_x, hit_y, hit_side, wall_face,
        input  ready
    );

    modport sink (
        input  valid, command, column_x, distance, hit_x, hit_y, hit_side, wall_face,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/rcwt_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcwt_out_if
// Pixel channel: one textured pixel of the column span per item.
// ----------------------------------------------------------------------------
interface rcwt_out_if;
    import rcwt_pkg::*;

    logic              valid;
    logic              ready;
    logic [COL_W-1:0]  out_column;
    logic [PROW_W-1:0] pixel_row;
    logic [FACE_W-1:0] texture_select;
    logic [TEX_W-1:0]  tex_u;
    logic [TEX_W-1:0]  tex_v;
    logic              last_in_column;

    modport source (
        output valid, out_column, pixel_row, texture_select, tex_u, tex_v, last_in_column,
        input  ready
    );

    modport sink (
        input  valid, out_column, pixel_row, texture_select, tex_u, tex_v, last_in_column,
        output ready
    );
endinterface

`default_nettype wire

// File: rtl/core/raycast_wall_column_texturer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// raycast_wall_column_texturer_core
// Textured wall column generator for a grid raycaster.
// ----------------------------------------------------------------------------
// A load item takes one ray hit and works out the projected wall height
// (projection distance times tile size over distance, saturated), the texture
// column and the visible row span clipped to the screen; it emits nothing.
// Each tick item then emits one pixel of the span, top to bottom, with its
// row, face, texture u and v, and a last flag on the final row; a tick with
// no open span emits nothing. Both commands share one restoring divider that
// yields one quotient bit per cycle. A load passes through prep, the height
// division (skipped when the height saturates) and the span step; a tick with
// an open span passes through prep and the texture row division. The input is
// not ready while an item is in work. A finished pixel sits in an output
// register, so the next item is taken while it waits; a pixel holds the
// sequencer only while the previous one is still untaken. Configuration is
// to be written only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module raycast_wall_column_texturer_core #(
    parameter int TILE_SIZE       = 64,
    parameter int MAX_SCREEN_ROWS = 4096,
    parameter int HEIGHT_BITS     = 16
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    rcwt_in_if.sink                        i_in,
    rcwt_out_if.source                     o_out,
    input  wire                            i_cfg_we,
    input  wire [rcwt_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire [rcwt_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rcwt_pkg::*;

    localparam int ROW_W  = $clog2(MAX_SCREEN_ROWS + 1);
    localparam int U_W    = $clog2(TILE_SIZE);
    localparam int TM_W   = $clog2(TILE_SIZE + 1);
    localparam int DEN_W  = (HEIGHT_BITS > DIST_W) ? HEIGHT_BITS : DIST_W;
    localparam int RW     = (HEIGHT_BITS > ROW_W) ? HEIGHT_BITS : ROW_W;
    localparam int AW     = RW + 1;
    localparam int NUMH_W = PD_W + 8 + TM_W;
    localparam int NUMV_W = HEIGHT_BITS + TM_W;
    localparam int NUM_W  = (NUMH_W > NUMV_W) ? NUMH_W : NUMV_W;
    localparam int SW     = (ROW_W > SH_W) ? ROW_W : SH_W;
    localparam int STEP_W = $clog2(HEIGHT_BITS + 1);
    localparam int UX_W   = (U_W > TEX_W) ? U_W : TEX_W;
    localparam int RX_W   = (ROW_W > PROW_W) ? ROW_W : PROW_W;
    localparam int UP_W   = FRAC_W + TM_W;
    localparam logic [HEIGHT_BITS-1:0] HMAX = '1;
    localparam logic [U_W-1:0]         TMAX = U_W'(TILE_SIZE - 1);

    // configuration registers
    logic [SH_W-1:0] r_sh;
    logic [PD_W-1:0] r_pd;

    // sequencer
    t_state r_state;
    t_state n_state;
    logic   r_is_tick;

    // column state
    logic                   r_span_active;
    logic [COL_W-1:0]       r_column;
    logic [ROW_W-1:0]       r_row;
    logic [ROW_W-1:0]       r_end;
    logic [RW-1:0]          r_top;
    logic [HEIGHT_BITS-1:0] r_height;
    logic [U_W-1:0]         r_tex_u;
    logic [FACE_W-1:0]      r_face;

    // work registers of the item in flight
    logic [NUM_W-1:0]  r_num;
    logic [DIST_W-1:0] r_dist;
    logic [ROW_W-1:0]  r_pend_row;
    logic              r_pend_last;

    // output register
    logic              r_ov;
    logic [COL_W-1:0]  r_o_column;
    logic [PROW_W-1:0] r_o_row;
    logic [FACE_W-1:0] r_o_face;
    logic [TEX_W-1:0]  r_o_u;
    logic [TEX_W-1:0]  r_o_v;
    logic              r_o_last;

    logic in_acc;
    logic out_free;

    // divider hookup
    t_div_status            div_status;
    logic [HEIGHT_BITS-1:0] div_quot;
    logic                   div_start;
    logic [DEN_W-1:0]       div_rem;
    logic [DEN_W-1:0]       div_den;
    logic [HEIGHT_BITS-1:0] div_low;
    logic [STEP_W-1:0]      div_steps;

    // load arithmetic
    logic [HIT_W-1:0]  coord;
    logic [UP_W-1:0]   u_prod;
    logic [U_W-1:0]    u_raw;
    logic [NUM_W-1:0]  num_load;
    logic [NUM_W-1:0]  num_hi;
    logic              h_sat;

    // tick arithmetic
    logic [RW-1:0]          rel_full;
    logic [NUM_W-1:0]       num_tick;
    logic [ROW_W:0]         row_next;
    logic                   tick_last;
    logic [U_W-1:0]         v_raw;
    logic [U_W-1:0]         v_clamp;
    logic [UX_W-1:0]        v_ext;
    logic [UX_W-1:0]        u_ext;
    logic [RX_W-1:0]        row_ext;

    // span arithmetic
    logic [SW-1:0]    sh_ext;
    logic [SW-1:0]    scr_w;
    logic [ROW_W-1:0] scr;
    logic [AW-1:0]    half_s;
    logic [AW-1:0]    half_h;
    logic [AW-1:0]    bottom;
    logic [AW-1:0]    top_raw;
    logic [AW-1:0]    start_a;
    logic [AW-1:0]    end_a;
    logic             top_neg;
    logic             span_ok;

    assign in_acc   = i_in.valid && i_in.ready;
    assign out_free = !r_ov || o_out.ready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sh <= SH_RESET;
            r_pd <= PD_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_SCREEN_HEIGHT: r_sh <= i_cfg_data[SH_W-1:0];
                REG_PROJ_DIST:     r_pd <= i_cfg_data[PD_W-1:0];
                default:           ;
            endcase
        end
    end

    // texture column from the fractional wall coordinate
    assign coord   = i_in.hit_side ? i_in.hit_x : i_in.hit_y;
    assign u_prod  = UP_W'(coord[FRAC_W-1:0]) * UP_W'(TILE_SIZE);
    assign u_raw   = u_prod[FRAC_W +: U_W];

    // height numerator and saturation test
    assign num_load = (NUM_W'(r_pd) << 8) * NUM_W'(TILE_SIZE);
    assign num_hi   = r_num >> HEIGHT_BITS;
    assign h_sat    = num_hi >= NUM_W'(r_dist);

    // texture row numerator and last row test
    assign rel_full  = RW'(r_row) - r_top;
    assign num_tick  = NUM_W'(rel_full[HEIGHT_BITS-1:0]) * NUM_W'(TILE_SIZE);
    assign row_next  = (ROW_W + 1)'(r_row) + (ROW_W + 1)'(1);
    assign tick_last = row_next >= (ROW_W + 1)'(r_end);

    // divider operands for the two commands
    always_comb begin
        div_start = (r_state == S_PREP) && (r_is_tick || !h_sat);
        if (r_is_tick) begin
            div_rem   = DEN_W'(r_num >> U_W);
            div_den   = DEN_W'(r_height);
            div_low   = HEIGHT_BITS'(r_num[U_W-1:0]) << (HEIGHT_BITS - U_W);
            div_steps = STEP_W'(U_W);
        end else begin
            div_rem   = DEN_W'(num_hi);
            div_den   = DEN_W'(r_dist);
            div_low   = r_num[HEIGHT_BITS-1:0];
            div_steps = STEP_W'(HEIGHT_BITS);
        end
    end

    rcwt_div #(
        .DEN_W  (DEN_W),
        .Q_W    (HEIGHT_BITS),
        .STEP_W (STEP_W)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_rem    (div_rem),
        .i_den    (div_den),
        .i_low    (div_low),
        .i_steps  (div_steps),
        .o_status (div_status),
        .o_quot   (div_quot)
    );

    // texture row, clamped to the tile
    assign v_raw   = div_quot[U_W-1:0];
    assign v_clamp = (v_raw > TMAX) ? TMAX : v_raw;
    assign v_ext   = UX_W'(v_clamp);
    assign u_ext   = UX_W'(r_tex_u);
    assign row_ext = RX_W'(r_pend_row);

    // visible span, clipped to the screen
    assign sh_ext  = SW'(r_sh);
    assign scr_w   = (sh_ext > SW'(MAX_SCREEN_ROWS)) ? SW'(MAX_SCREEN_ROWS) : sh_ext;
    assign scr     = scr_w[ROW_W-1:0];
    assign half_s  = AW'(scr >> 1);
    assign half_h  = AW'(r_height >> 1);
    assign bottom  = half_s + half_h;
    assign top_raw = half_s - half_h;
    assign top_neg = half_h > half_s;
    assign start_a = top_neg ? '0 : top_raw;
    assign end_a   = (bottom > AW'(scr)) ? AW'(scr) : bottom;
    assign span_ok = start_a < end_a;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in.command == CMD_LOAD || r_span_active)) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_state = (!r_is_tick && h_sat) ? S_SPAN : S_DIV;
            end
            S_DIV: begin
                if (div_status.done) begin
                    if (!r_is_tick) begin
                        n_state = S_SPAN;
                    end else if (out_free) begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_SPAN: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign i_in.ready = (r_state == S_IDLE);

    // item capture and column state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_is_tick     <= 1'b0;
            r_span_active <= 1'b0;
            r_column      <= '0;
            r_row         <= '0;
            r_end         <= '0;
            r_top         <= '0;
            r_height      <= '0;
            r_tex_u       <= '0;
            r_face        <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_is_tick <= (i_in.command == CMD_TICK);
                        if (i_in.command == CMD_LOAD) begin
                            r_column <= i_in.column_x;
                            r_face   <= i_in.wall_face;
                            r_tex_u  <= (u_raw > TMAX) ? TMAX : u_raw;
                        end else if (r_span_active) begin
                            // step the span at accept, the pending row keeps the old one
                            if (tick_last) begin
                                r_span_active <= 1'b0;
                            end else begin
                                r_row <= row_next[ROW_W-1:0];
                            end
                        end
                    end
                end
                S_PREP: begin
                    if (!r_is_tick && h_sat) begin
                        r_height <= HMAX;
                    end
                end
                S_DIV: begin
                    if (div_status.done && !r_is_tick) begin
                        r_height <= div_quot;
                    end
                end
                S_SPAN: begin
                    r_top <= top_raw[RW-1:0];
                    if (span_ok) begin
                        r_span_active <= 1'b1;
                        r_row         <= start_a[ROW_W-1:0];
                        r_end         <= end_a[ROW_W-1:0];
                    end else begin
                        r_span_active <= 1'b0;
                        r_row         <= '0;
                        r_end         <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // work registers, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dist      <= i_in.distance;
            r_num       <= (i_in.command == CMD_LOAD) ? num_load : num_tick;
            r_pend_row  <= r_row;
            r_pend_last <= tick_last;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (r_state == S_DIV && div_status.done && r_is_tick && out_free) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DIV && div_status.done && r_is_tick && out_free) begin
            r_o_column <= r_column;
            r_o_row    <= row_ext[PROW_W-1:0];
            r_o_face   <= r_face;
            r_o_u      <= u_ext[TEX_W-1:0];
            r_o_v      <= v_ext[TEX_W-1:0];
            r_o_last   <= r_pend_last;
        end
    end

    assign o_out.valid          = r_ov;
    assign o_out.out_column     = r_o_column;
    assign o_out.pixel_row      = r_o_row;
    assign o_out.texture_select = r_o_face;
    assign o_out.tex_u          = r_o_u;
    assign o_out.tex_v          = r_o_v;
    assign o_out.last_in_column = r_o_last;

endmodule

`default_nettype wire

// File: rtl/core/rcwt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rcwt_div
// Restoring radix-2 divider, one quotient bit per cycle. The caller preloads
// a partial remainder below the divisor and the low numerator bits, left
// aligned, plus the number of quotient bits to produce.
// ----------------------------------------------------------------------------
module rcwt_div #(
    parameter int DEN_W  = 24,
    parameter int Q_W    = 16,
    parameter int STEP_W = 5
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_start,
    input  wire [DEN_W-1:0]          i_rem,
    input  wire [DEN_W-1:0]          i_den,
    input  wire [Q_W-1:0]            i_low,
    input  wire [STEP_W-1:0]         i_steps,
    output rcwt_pkg::t_div_status    o_status,
    output logic [Q_W-1:0]           o_quot
);
    import rcwt_pkg::*;

    logic [DEN_W-1:0]  r_rem;
    logic [DEN_W-1:0]  r_den;
    logic [Q_W-1:0]    r_low;
    logic [Q_W-1:0]    r_quot;
    logic [STEP_W-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [DEN_W:0]    trial;
    logic [DEN_W+1:0]  diff;
    logic              fits;

    // trial subtract of the divisor from the shifted remainder
    assign trial = {r_rem, r_low[Q_W-1]};
    assign diff  = {1'b0, trial} - {2'b00, r_den};
    assign fits  = ~diff[DEN_W+1];

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= i_steps;
        end else if (r_busy) begin
            r_cnt <= r_cnt - STEP_W'(1);
            if (r_cnt == STEP_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_den  <= i_den;
            r_low  <= i_low;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            r_low  <= {r_low[Q_W-2:0], 1'b0};
            r_quot <= {r_quot[Q_W-2:0], fits};
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule

`default_nettype wire
